@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ps2mpd_pkg.sv @@
// Package with the types and constants of the PS/2 mouse packet decoder.
package ps2mpd_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] ACK_BYTE  = 8'hFA;
  localparam logic [7:0] SYNC_MASK = 8'hC8;
  localparam logic [7:0] SYNC_VAL  = 8'h08;

  localparam int unsigned BIT_LEFT   = 0;
  localparam int unsigned BIT_RIGHT  = 1;
  localparam int unsigned BIT_MIDDLE = 2;
  localparam int unsigned BIT_XSIGN  = 4;
  localparam int unsigned BIT_YSIGN  = 5;
  localparam int unsigned BIT_FOURTH = 4;
  localparam int unsigned BIT_FIFTH  = 5;

  typedef enum logic [4:0] {
    ST_ACK    = 5'b00001,
    ST_STATUS = 5'b00010,
    ST_X      = 5'b00100,
    ST_Y      = 5'b01000,
    ST_EXT    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [7:0] ext;
    logic       has_ext;
  } packet_t;

  typedef struct packed {
    logic    push;
    packet_t pkt;
  } push_t;

endpackage

@@ src/ps2mpd_front.sv @@
// Front part: accepts received bytes, tracks the packet phase and assembles packets.
module ps2mpd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_rx_byte,
  input  logic                 q_full,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  output logic                 in_stall,
  output ps2mpd_pkg::push_t    q_wr
);
  import ps2mpd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       wheel_r;
  logic [7:0] status_r, status_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] y_r, y_nxt;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    phase_nxt       = phase_r;
    status_nxt      = status_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    q_wr.push       = 1'b0;
    q_wr.pkt.status = status_r;
    q_wr.pkt.x_byte = x_r;
    q_wr.pkt.y_byte = in_rx_byte;
    q_wr.pkt.ext    = 8'h00;
    q_wr.pkt.has_ext = 1'b0;
    if (accept) begin
      unique case (phase_r)
        ST_STATUS: begin
          if ((in_rx_byte & SYNC_MASK) == SYNC_VAL) begin
            status_nxt = in_rx_byte;
            phase_nxt  = ST_X;
          end
        end
        ST_X: begin
          x_nxt     = in_rx_byte;
          phase_nxt = ST_Y;
        end
        ST_Y: begin
          y_nxt = in_rx_byte;
          if (wheel_r) begin
            phase_nxt = ST_EXT;
          end else begin
            phase_nxt = ST_STATUS;
            q_wr.push = 1'b1;
          end
        end
        ST_EXT: begin
          phase_nxt        = ST_STATUS;
          q_wr.push        = 1'b1;
          q_wr.pkt.y_byte  = y_r;
          q_wr.pkt.ext     = in_rx_byte;
          q_wr.pkt.has_ext = 1'b1;
        end
        default: begin
          if (in_rx_byte == ACK_BYTE) begin
            phase_nxt = ST_STATUS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ST_ACK;
      wheel_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (cfg_wr_en) begin
        wheel_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
  end

endmodule

@@ src/ps2mpd_queue.sv @@
// Short packet queue between the front and the back part.
module ps2mpd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ps2mpd_pkg::push_t    q_wr,
  input  logic                 q_pop,
  output logic                 q_full,
  output logic                 q_valid,
  output ps2mpd_pkg::packet_t  q_pkt
);
  import ps2mpd_pkg::*;

  packet_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_pkt   = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.pkt;
    end
  end

endmodule

@@ src/ps2mpd_back.sv @@
// Back part: decodes queued packets into result fields held in an output register.
module ps2mpd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ps2mpd_pkg::packet_t  q_pkt,
  output logic                 q_pop,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_button_left,
  output logic                 out_button_right,
  output logic                 out_button_middle,
  output logic                 out_button_fourth,
  output logic                 out_button_fifth,
  output logic signed [8:0]    out_x_move,
  output logic signed [8:0]    out_y_move,
  output logic signed [3:0]    out_z_move
);
  import ps2mpd_pkg::*;

  logic              valid_r;
  logic              left_r, right_r, middle_r, fourth_r, fifth_r;
  logic signed [8:0] x_r, y_r;
  logic signed [3:0] z_r;
  logic              load;

  assign load  = q_valid && (!valid_r || !out_stall);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r   <= q_pkt.status[BIT_LEFT];
      right_r  <= q_pkt.status[BIT_RIGHT];
      middle_r <= q_pkt.status[BIT_MIDDLE];
      fourth_r <= q_pkt.has_ext & q_pkt.ext[BIT_FOURTH];
      fifth_r  <= q_pkt.has_ext & q_pkt.ext[BIT_FIFTH];
      x_r      <= {q_pkt.status[BIT_XSIGN], q_pkt.x_byte};
      y_r      <= {q_pkt.status[BIT_YSIGN], q_pkt.y_byte};
      z_r      <= q_pkt.has_ext ? q_pkt.ext[3:0] : 4'sd0;
    end
  end

  assign out_valid         = valid_r;
  assign out_button_left   = left_r;
  assign out_button_right  = right_r;
  assign out_button_middle = middle_r;
  assign out_button_fourth = fourth_r;
  assign out_button_fifth  = fifth_r;
  assign out_x_move        = x_r;
  assign out_y_move        = y_r;
  assign out_z_move        = z_r;

endmodule

@@ src/ps2_mouse_packet_decoder.sv @@
// Top level of the PS/2 mouse packet decoder: front part, packet queue and back part.
// Throughput: one received byte per cycle; a byte is stalled only while the queue is full.
// Path: the byte that completes a packet is written into the packet queue, and its result
// is then loaded from the queue into the output register.
// Reset: synchronous, active low; clears phase to awaiting acknowledge, wheel mode to off,
// and empties the queue and output register.
module ps2_mouse_packet_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_button_left,
  output logic              out_button_right,
  output logic              out_button_middle,
  output logic              out_button_fourth,
  output logic              out_button_fifth,
  output logic signed [8:0] out_x_move,
  output logic signed [8:0] out_y_move,
  output logic signed [3:0] out_z_move
);
  import ps2mpd_pkg::*;

  push_t   q_wr;
  packet_t q_pkt;
  logic    q_full, q_valid, q_pop;

  ps2mpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_rx_byte  (in_rx_byte),
    .q_full      (q_full),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_stall    (in_stall),
    .q_wr        (q_wr)
  );

  ps2mpd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_pkt   (q_pkt)
  );

  ps2mpd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pkt             (q_pkt),
    .q_pop             (q_pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_button_left   (out_button_left),
    .out_button_right  (out_button_right),
    .out_button_middle (out_button_middle),
    .out_button_fourth (out_button_fourth),
    .out_button_fifth  (out_button_fifth),
    .out_x_move        (out_x_move),
    .out_y_move        (out_y_move),
    .out_z_move        (out_z_move)
  );

endmodule

@@ src/ps2mpd_checker.sv @@
// Port-level assertion checker for the PS/2 mouse packet decoder, with its bind.
`include "assert_macros.svh"

module ps2mpd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_wr_en,
  input logic              cfg_wr_data,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        in_rx_byte,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_button_left,
  input logic              out_button_right,
  input logic              out_button_middle,
  input logic              out_button_fourth,
  input logic              out_button_fifth,
  input logic signed [8:0] out_x_move,
  input logic signed [8:0] out_y_move,
  input logic signed [3:0] out_z_move
);

  // A result beat that is stalled stays offered.
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")

  // A stalled result beat keeps its moves.
  `ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable(out_x_move) && $stable(out_y_move) && $stable(out_z_move), "stalled result beat changed")

  // Reset empties the output register.
  `ASSERT_CLK_ALWAYS(a_rst_out, $past(!rst_n) |-> !out_valid, "result beat offered right after reset")

  // Reset empties the queue, so the input side is free right after it.
  `ASSERT_CLK_ALWAYS(a_rst_in, $past(!rst_n) |-> !in_stall, "input stalled right after reset")

endmodule

bind ps2_mouse_packet_decoder ps2mpd_checker u_checker (.*);

@@ tb/ps2mpd_packet_checker.sv @@
// Checker for the PS/2 mouse packet decoder: tracks packets and compares every result beat.
module ps2mpd_packet_checker
  import ps2mpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_button_left,
  input  logic              out_button_right,
  input  logic              out_button_middle,
  input  logic              out_button_fourth,
  input  logic              out_button_fifth,
  input  logic signed [8:0] out_x_move,
  input  logic signed [8:0] out_y_move,
  input  logic signed [3:0] out_z_move,
  output int                mismatches,
  output int                reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              left;
    logic              right;
    logic              middle;
    logic              fourth;
    logic              fifth;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic signed [3:0] z;
  } report_t;

  report_t    reports_due[$];
  phase_t     pkt_phase;
  logic       wheel_on;
  logic [7:0] status_q;
  logic [7:0] x_q;
  logic [7:0] y_q;

  function automatic report_t make_report(input logic [7:0] st, input logic [7:0] xb,
                                          input logic [7:0] yb, input logic [7:0] ext,
                                          input logic has_ext);
    report_t r;
    r.left   = st[BIT_LEFT];
    r.right  = st[BIT_RIGHT];
    r.middle = st[BIT_MIDDLE];
    r.fourth = has_ext & ext[BIT_FOURTH];
    r.fifth  = has_ext & ext[BIT_FIFTH];
    r.x      = {st[BIT_XSIGN], xb};
    r.y      = {st[BIT_YSIGN], yb};
    r.z      = has_ext ? ext[3:0] : 4'sd0;
    return r;
  endfunction

  function automatic string show(input report_t r);
    return $sformatf("L%0b R%0b M%0b B4 %0b B5 %0b X %0d Y %0d Z %0d", r.left, r.right,
                     r.middle, r.fourth, r.fifth, $signed(r.x), $signed(r.y), $signed(r.z));
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    case (pkt_phase)
      ST_STATUS: begin
        if ((b & SYNC_MASK) == SYNC_VAL) begin
          status_q  = b;
          pkt_phase = ST_X;
        end
      end
      ST_X: begin
        x_q       = b;
        pkt_phase = ST_Y;
      end
      ST_Y: begin
        y_q = b;
        if (wheel_on) begin
          pkt_phase = ST_EXT;
        end else begin
          pkt_phase = ST_STATUS;
          reports_due.push_back(make_report(status_q, x_q, y_q, 8'h00, 1'b0));
        end
      end
      ST_EXT: begin
        pkt_phase = ST_STATUS;
        reports_due.push_back(make_report(status_q, x_q, y_q, b, 1'b1));
      end
      default: begin
        if (b == ACK_BYTE) pkt_phase = ST_STATUS;
      end
    endcase
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst_n) begin
      pkt_phase  = ST_ACK;
      wheel_on   = 1'b0;
      status_q   = 8'h00;
      x_q        = 8'h00;
      y_q        = 8'h00;
      mismatches = 0;
      reports_due.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_rx_byte);
      if (cfg_wr_en) wheel_on = cfg_wr_data;
      if (out_valid && !out_stall) begin
        got = '{out_button_left, out_button_right, out_button_middle, out_button_fourth,
                out_button_fifth, out_x_move, out_y_move, out_z_move};
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result beat with none expected: %s", $time,
                                         show(got));
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: expected %s, got %s", $time, show(want),
                                           show(got));
          end
        end
      end
    end
    reports_pending = reports_due.size();
  end

endmodule

@@ tb/tb_ps2_mouse_packet_decoder.sv @@
// Testbench top for the PS/2 mouse packet decoder: clock, reset, stimulus and verdict.
module tb_ps2_mouse_packet_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import ps2mpd_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_stall;
  logic              out_button_left;
  logic              out_button_right;
  logic              out_button_middle;
  logic              out_button_fourth;
  logic              out_button_fifth;
  logic signed [8:0] out_x_move;
  logic signed [8:0] out_y_move;
  logic signed [3:0] out_z_move;
  int                mismatches;
  int                reports_pending;
  int                idle_cycles;
  bit                send_burst;
  logic              wheel_now;

  ps2_mouse_packet_decoder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_button_left   (out_button_left),
    .out_button_right  (out_button_right),
    .out_button_middle (out_button_middle),
    .out_button_fourth (out_button_fourth),
    .out_button_fifth  (out_button_fifth),
    .out_x_move        (out_x_move),
    .out_y_move        (out_y_move),
    .out_z_move        (out_z_move)
  );

  ps2mpd_packet_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_button_left   (out_button_left),
    .out_button_right  (out_button_right),
    .out_button_middle (out_button_middle),
    .out_button_fourth (out_button_fourth),
    .out_button_fifth  (out_button_fifth),
    .out_x_move        (out_x_move),
    .out_y_move        (out_y_move),
    .out_z_move        (out_z_move),
    .mismatches        (mismatches),
    .reports_pending   (reports_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ps2_mouse_packet_decoder regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet(input int nbytes);
    logic [7:0] st;
    st      = 8'($urandom);
    st[7:6] = 2'b00;
    st[3]   = 1'b1;
    send_byte(st);
    for (int i = 1; i < nbytes; i++) send_byte(8'($urandom));
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_wheel(input logic v);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    wheel_now   = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin : receiver
    int gap;
    int beats;
    bit burst;
    beats = 0;
    burst = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 12);
      if (beats == 20) gap = 400;
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int         data_bytes;
    int         target;
    int         pick;
    logic [7:0] b;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    send_burst  = 1'b0;
    wheel_now   = 1'b0;
    data_bytes  = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Bytes before the acknowledge are dropped, even one that looks like a status byte.
    send_byte(8'hFF);
    send_byte(8'h08);
    send_byte(ACK_BYTE);
    send_byte(8'hC8);
    send_byte(8'h87);
    send_byte(8'h3F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h08);
    send_byte(8'hFF);
    send_byte(ACK_BYTE);
    set_wheel(1'b1);
    send_byte(8'h0F);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h38);
    // A packet that has passed its Y byte in wheel mode still ends with four bytes.
    send_byte(8'h2C);
    send_byte(8'h01);
    send_byte(8'h02);
    set_wheel(1'b0);
    send_byte(8'hC7);
    // Wheel mode takes effect when it is set before the Y byte arrives.
    send_byte(8'h1B);
    send_byte(8'h11);
    set_wheel(1'b1);
    send_byte(8'h22);
    send_byte(8'h05);

    for (int ph = 0; ph < 6; ph++) begin
      set_wheel(ph == 0 ? 1'b0 : (ph == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
      target = data_bytes + 100;
      while (data_bytes < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_packet(wheel_now ? 4 : 3);
          data_bytes += wheel_now ? 4 : 3;
        end else if (pick < 90) begin
          b = 8'($urandom);
          if ($urandom_range(0, 1)) b[3] = 1'b0;
          else b[7:6] = 2'($urandom_range(1, 3));
          send_byte(b);
        end else if (pick < 94) begin
          send_byte(ACK_BYTE);
        end else if (pick < 97) begin
          send_byte(8'($urandom));
        end else begin
          send_packet($urandom_range(1, wheel_now ? 3 : 2));
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("ps2_mouse_packet_decoder regression: pass");
    end else begin
      $display("ps2_mouse_packet_decoder regression: fail");
    end
    $finish;
  end

endmodule
